// ===== sv/glp_pkg.sv =====
// ----------------------------------------------------------------------------
// glp_pkg
// Shared types, codes and helpers for the gamma curve pixel mapper.
// ----------------------------------------------------------------------------
package glp_pkg;

    localparam logic       CMD_LOAD  = 1'b0;
    localparam logic       CMD_PIXEL = 1'b1;

    localparam logic [1:0] FMT_INDEX8   = 2'd0;
    localparam logic [1:0] FMT_RGB565   = 2'd1;
    localparam logic [1:0] FMT_ARGB4444 = 2'd2;
    localparam logic [1:0] FMT_RAW      = 2'd3;

    localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] CFG_USE_INVERSE  = 2'd1;
    localparam logic [1:0] CFG_KEY_ENABLE   = 2'd2;
    localparam logic [1:0] CFG_KEY_VALUE    = 2'd3;

    localparam logic [7:0] LEVEL_MAX = 8'd255;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [1:0]  pixel_format;
        logic        use_inverse;
        logic        key_enable;
        logic [15:0] key_value;
    } t_cfg;

    typedef struct packed {
        logic        is_load;
        logic        bypass;
        logic        passed;
        logic [7:0]  entry_index;
        logic [7:0]  entry_value;
        logic [15:0] pixel;
        logic [7:0]  addr0;
        logic [7:0]  addr1;
        logic [7:0]  addr2;
    } t_item;

    function automatic logic [15:0] f_key(input t_cfg cfg);
        logic [15:0] key;
        key = cfg.key_value;
        if (cfg.pixel_format == FMT_INDEX8) begin
            key = {8'h00, cfg.key_value[7:0]};
        end
        return key;
    endfunction

endpackage

// ===== sv/glp_front.sv =====
// ----------------------------------------------------------------------------
// glp_front
// Accepts items, splits pixels into table addresses, flags raw/key bypass.
// ----------------------------------------------------------------------------
module glp_front (
    input  glp_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    input  logic           i_cmd,
    input  logic [7:0]     i_entry_index,
    input  logic [7:0]     i_entry_value,
    input  logic [15:0]    i_pixel_in,
    input  logic           i_full,
    output logic           o_stall,
    output logic           o_push,
    output glp_pkg::t_item o_item
);
    import glp_pkg::*;

    logic [15:0] w_key;
    logic [15:0] w_pix;
    logic        w_passed;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        w_key    = f_key(i_cfg);
        w_pix    = i_pixel_in;
        if (i_cfg.pixel_format == FMT_INDEX8) begin
            w_pix = {8'h00, i_pixel_in[7:0]};
        end
        w_passed = i_cfg.key_enable && (i_cfg.pixel_format != FMT_RAW) && (w_pix == w_key);

        o_item.is_load     = (i_cmd == CMD_LOAD);
        o_item.bypass      = (i_cfg.pixel_format == FMT_RAW) || w_passed;
        o_item.passed      = w_passed;
        o_item.entry_index = i_entry_index;
        o_item.entry_value = i_entry_value;
        o_item.pixel       = w_pix;

        unique case (i_cfg.pixel_format)
            FMT_INDEX8: begin
                o_item.addr0 = 8'h00;
                o_item.addr1 = 8'h00;
                o_item.addr2 = i_pixel_in[7:0];
            end
            FMT_RGB565: begin
                o_item.addr0 = {i_pixel_in[15:11], 3'b000};
                o_item.addr1 = {i_pixel_in[10:5], 2'b00};
                o_item.addr2 = {i_pixel_in[4:0], 3'b000};
            end
            FMT_ARGB4444: begin
                o_item.addr0 = {i_pixel_in[11:8], 4'h0};
                o_item.addr1 = {i_pixel_in[7:4], 4'h0};
                o_item.addr2 = {i_pixel_in[3:0], 4'h0};
            end
            default: begin
                o_item.addr0 = 8'h00;
                o_item.addr1 = 8'h00;
                o_item.addr2 = 8'h00;
            end
        endcase
    end

endmodule

// ===== sv/glp_queue.sv =====
// ----------------------------------------------------------------------------
// glp_queue
// Two-entry item queue between the front and back ends.
// ----------------------------------------------------------------------------
module glp_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  glp_pkg::t_item                i_item,
    input  logic                          i_pop,
    output logic                          o_full,
    output logic                          o_empty,
    output glp_pkg::t_item                o_item,
    output logic [glp_pkg::Q_CNT_W-1:0]   o_count
);
    import glp_pkg::*;

    t_item               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wp;
    logic [Q_PTR_W-1:0]  r_rp;
    logic [Q_CNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== sv/glp_back.sv =====
// ----------------------------------------------------------------------------
// glp_back
// Curve tables, load/fill sequencer, channel lookups and output register.
// ----------------------------------------------------------------------------
module glp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  glp_pkg::t_cfg  i_cfg,
    input  logic           i_empty,
    input  glp_pkg::t_item i_item,
    input  logic           i_stall,
    output logic           o_pop,
    output logic           o_valid,
    output logic [15:0]    o_pixel_out,
    output logic           o_key_passed,
    output logic           o_key_dodged
);
    import glp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD2  = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;
    localparam logic [1:0] ST_PIN  = 2'd3;

    logic [7:0]  r_fwd [256];
    logic [7:0]  r_inv [256];
    logic [7:0]  r_fwd_rd0;
    logic [7:0]  r_fwd_rd1;
    logic [7:0]  r_inv_rd0;
    logic [7:0]  r_inv_rd1;

    logic [1:0]  r_state, n_state;
    logic [7:0]  r_fill, n_fill;
    logic [7:0]  r_lv, n_lv;
    logic [7:0]  r_end, n_end;
    logic [7:0]  r_wdat, n_wdat;
    logic        r_pin, n_pin;

    logic        r_fin_vld, n_fin_vld;
    logic        r_fin_bypass;
    logic        r_fin_passed;
    logic [15:0] r_fin_pixel;
    logic [7:0]  r_c0;
    logic [7:0]  r_c1;

    logic        r_out_vld;
    logic [15:0] r_out_pixel;
    logic        r_out_passed;
    logic        r_out_dodged;

    logic        w_rd_en;
    logic [7:0]  w_ra0;
    logic [7:0]  w_ra1;
    logic        w_fwd_we;
    logic [7:0]  w_fwd_wa;
    logic [7:0]  w_fwd_wd;
    logic        w_inv_we;
    logic [7:0]  w_inv_wa;
    logic [7:0]  w_inv_wd;
    logic [7:0]  w_t0;
    logic [7:0]  w_t1;
    logic [7:0]  w_f;
    logic        w_out_free;
    logic        w_fin_done;
    logic        w_fin_free;
    logic        w_fin_load;
    logic [15:0] w_key;
    logic [15:0] w_map;
    logic        w_hit;
    logic [15:0] w_res;
    logic        w_res_passed;
    logic        w_res_dodged;

    always_ff @(posedge i_clk) begin
        if (w_fwd_we) begin
            r_fwd[w_fwd_wa] <= w_fwd_wd;
        end
        if (w_rd_en) begin
            r_fwd_rd0 <= r_fwd[w_ra0];
            r_fwd_rd1 <= r_fwd[w_ra1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_inv_we) begin
            r_inv[w_inv_wa] <= w_inv_wd;
        end
        if (w_rd_en) begin
            r_inv_rd0 <= r_inv[w_ra0];
            r_inv_rd1 <= r_inv[w_ra1];
        end
    end

    assign w_t0       = i_cfg.use_inverse ? r_inv_rd0 : r_fwd_rd0;
    assign w_t1       = i_cfg.use_inverse ? r_inv_rd1 : r_fwd_rd1;
    assign w_out_free = !r_out_vld || !i_stall;
    assign w_fin_done = r_fin_vld && w_out_free;
    assign w_fin_free = !r_fin_vld || w_fin_done;
    assign w_f        = (i_item.entry_index == 8'd0) ? 8'd0 : r_fill;
    assign w_ra0      = (r_state == ST_RD2) ? i_item.addr2 : i_item.addr0;
    assign w_ra1      = i_item.addr1;

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_lv       = r_lv;
        n_end      = r_end;
        n_wdat     = r_wdat;
        n_pin      = r_pin;
        o_pop      = 1'b0;
        w_rd_en    = 1'b0;
        w_fin_load = 1'b0;
        w_fwd_we   = 1'b0;
        w_fwd_wa   = i_item.entry_index;
        w_fwd_wd   = i_item.entry_value;
        w_inv_we   = 1'b0;
        w_inv_wa   = r_lv;
        w_inv_wd   = r_wdat;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    if (i_item.is_load) begin
                        o_pop    = 1'b1;
                        w_fwd_we = 1'b1;
                        if (i_item.entry_index == LEVEL_MAX) begin
                            w_fwd_wd = LEVEL_MAX;
                            n_fill   = 8'd0;
                            n_lv     = (i_item.entry_value < w_f) ? i_item.entry_value : w_f;
                            n_end    = LEVEL_MAX;
                            n_wdat   = LEVEL_MAX;
                            n_pin    = 1'b1;
                            n_state  = ST_FILL;
                        end else begin
                            n_fill = i_item.entry_value;
                            n_lv   = w_f;
                            n_end  = i_item.entry_value;
                            n_wdat = i_item.entry_index;
                            n_pin  = 1'b0;
                            if (i_item.entry_value >= w_f) begin
                                n_state = ST_FILL;
                            end
                        end
                    end else if (w_fin_free) begin
                        if (i_item.bypass) begin
                            o_pop      = 1'b1;
                            w_fin_load = 1'b1;
                        end else begin
                            w_rd_en = 1'b1;
                            n_state = ST_RD2;
                        end
                    end
                end
            end
            ST_RD2: begin
                w_rd_en    = 1'b1;
                o_pop      = 1'b1;
                w_fin_load = 1'b1;
                n_state    = ST_IDLE;
            end
            ST_FILL: begin
                w_inv_we = 1'b1;
                if (r_lv == r_end) begin
                    n_state = r_pin ? ST_PIN : ST_IDLE;
                end else begin
                    n_lv = r_lv + 8'd1;
                end
            end
            ST_PIN: begin
                w_fwd_we = 1'b1;
                w_fwd_wa = 8'd0;
                w_fwd_wd = 8'd0;
                w_inv_we = 1'b1;
                w_inv_wa = 8'd0;
                w_inv_wd = 8'd0;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_fin_vld = (r_fin_vld && !w_fin_done) || w_fin_load;
    end

    always_comb begin
        w_key = f_key(i_cfg);
        unique case (i_cfg.pixel_format)
            FMT_INDEX8:   w_map = {8'h00, w_t0};
            FMT_RGB565:   w_map = {r_c0[7:3], r_c1[7:2], w_t0[7:3]};
            FMT_ARGB4444: w_map = {r_fin_pixel[15:12], r_c0[7:4], r_c1[7:4], w_t0[7:4]};
            default:      w_map = r_fin_pixel;
        endcase
        w_hit = i_cfg.key_enable && (w_map == w_key);
        if (r_fin_bypass) begin
            w_res        = r_fin_pixel;
            w_res_passed = r_fin_passed;
            w_res_dodged = 1'b0;
        end else begin
            w_res        = w_map ^ {15'h0000, w_hit};
            w_res_passed = 1'b0;
            w_res_dodged = w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lv   <= n_lv;
        r_end  <= n_end;
        r_wdat <= n_wdat;
        r_pin  <= n_pin;
        if (w_fin_load) begin
            r_fin_bypass <= i_item.bypass;
            r_fin_passed <= i_item.passed;
            r_fin_pixel  <= i_item.pixel;
            r_c0         <= w_t0;
            r_c1         <= w_t1;
        end
        if (w_fin_done) begin
            r_out_pixel  <= w_res;
            r_out_passed <= w_res_passed;
            r_out_dodged <= w_res_dodged;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= 8'd0;
            r_fin_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_fin_vld <= n_fin_vld;
            if (w_fin_done) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_vld;
    assign o_pixel_out  = r_out_pixel;
    assign o_key_passed = r_out_passed;
    assign o_key_dodged = r_out_dodged;

endmodule

// ===== sv/gamma_lut_pixel_mapper.sv =====
// An accepted pixel passes the item queue, the final-stage and output registers,
// and, if it needs lookups, the table read registers. Three channel lookups share
// the two table read ports, so a lookup pixel takes a second read state. Colour-key
// and raw-format pixels need no lookup. Curve load: each entry is written, then
// the fill state writes inverse levels in turn; entry 255 adds a pinning state.
// Reset clears control and configuration; curve tables are undefined until loaded.
// ----------------------------------------------------------------------------
// gamma_lut_pixel_mapper
// Gamma curve loader and per-channel pixel remapper with colour-key handling.
// ----------------------------------------------------------------------------
module gamma_lut_pixel_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_entry_index,
    input  logic [7:0]  i_entry_value,
    input  logic [15:0] i_pixel_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_pixel_out,
    output logic        o_key_passed,
    output logic        o_key_dodged
);
    import glp_pkg::*;

    t_cfg               r_cfg;
    t_item              w_front_item;
    t_item              w_head_item;
    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_empty;
    logic [Q_CNT_W-1:0] w_q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_format <= FMT_RGB565;
            r_cfg.use_inverse  <= 1'b0;
            r_cfg.key_enable   <= 1'b0;
            r_cfg.key_value    <= 16'h0000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PIXEL_FORMAT: r_cfg.pixel_format <= i_cfg_data[1:0];
                CFG_USE_INVERSE:  r_cfg.use_inverse  <= i_cfg_data[0];
                CFG_KEY_ENABLE:   r_cfg.key_enable   <= i_cfg_data[0];
                CFG_KEY_VALUE:    r_cfg.key_value    <= i_cfg_data;
                default:          r_cfg.key_value    <= r_cfg.key_value;
            endcase
        end
    end

    glp_front u_front (
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .i_cmd         (i_cmd),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_pixel_in    (i_pixel_in),
        .i_full        (w_full),
        .o_stall       (o_stall),
        .o_push        (w_push),
        .o_item        (w_front_item)
    );

    glp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_item  (w_head_item),
        .o_count (w_q_count)
    );

    glp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_empty      (w_empty),
        .i_item       (w_head_item),
        .i_stall      (i_stall),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .o_pixel_out  (o_pixel_out),
        .o_key_passed (o_key_passed),
        .o_key_dodged (o_key_dodged)
    );

`ifndef SYNTH
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs not idle after reset");

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_q_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && w_push && !w_pop |=> w_q_count == $past(w_q_count) + 1'b1)
        else $error("queue count did not advance on push");
`endif

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the gamma curve pixel mapper. It loads full and
// partial curves, walks every pixel format with the colour key on and off,
// and compares each mapped pixel with a local model of the curve tables.
// Both ports see random gaps; configuration changes only when the block is
// idle.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import glp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned QUIET_CYCLES = 1000;
    localparam int unsigned RANDOM_ITEMS = 1450;
    localparam int unsigned MAX_PRINTS   = 50;

    typedef struct packed {
        logic [15:0] pixel;
        logic        passed;
        logic        dodged;
    } mapped_pixel_t;

    typedef enum {
        CURVE_IDENTITY,
        CURVE_SQUARE,
        CURVE_WALK,
        CURVE_FLAT_LOW,
        CURVE_FLAT_HIGH,
        CURVE_NOISE
    } curve_style_e;

    class gamma_scoreboard;
        logic [7:0]    curve_fwd [256];
        logic [7:0]    curve_inv [256];
        logic [8:0]    fill_lvl;
        logic [1:0]    fmt;
        logic          use_inv;
        logic          key_en;
        logic [15:0]   key_val;
        mapped_pixel_t expected_pixels [$];
        int unsigned   mismatches;

        function new();
            foreach (curve_fwd[i]) begin
                curve_fwd[i] = 8'd0;
                curve_inv[i] = 8'd0;
            end
            fill_lvl   = 9'd0;
            fmt        = FMT_RGB565;
            use_inv    = 1'b0;
            key_en     = 1'b0;
            key_val    = 16'd0;
            mismatches = 0;
        endfunction

        function void note_config(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_PIXEL_FORMAT: fmt = data[1:0];
                CFG_USE_INVERSE:  use_inv = data[0];
                CFG_KEY_ENABLE:   key_en = data[0];
                CFG_KEY_VALUE:    key_val = data;
                default: ;
            endcase
        endfunction

        function logic [7:0] curve_at(logic [7:0] level);
            return use_inv ? curve_inv[level] : curve_fwd[level];
        endfunction

        function void load_entry(logic [7:0] idx, logic [7:0] val);
            int lv;
            if (idx == 8'd0) begin
                fill_lvl = 9'd0;
            end
            curve_fwd[idx] = val;
            for (lv = fill_lvl; lv <= val; lv++) begin
                curve_inv[lv] = idx;
            end
            fill_lvl = {1'b0, val};
            if (idx == LEVEL_MAX) begin
                for (lv = val; lv < 256; lv++) begin
                    curve_inv[lv] = LEVEL_MAX;
                end
                curve_fwd[0]   = 8'd0;
                curve_inv[0]   = 8'd0;
                curve_fwd[255] = LEVEL_MAX;
                curve_inv[255] = LEVEL_MAX;
                fill_lvl       = 9'd0;
            end
        endfunction

        function logic [15:0] remap(logic [15:0] p);
            logic [7:0] r, g, b;
            if (fmt == FMT_INDEX8) begin
                return {8'h00, curve_at(p[7:0])};
            end
            if (fmt == FMT_RGB565) begin
                r = curve_at({p[15:11], 3'b000});
                g = curve_at({p[10:5], 2'b00});
                b = curve_at({p[4:0], 3'b000});
                return {r[7:3], g[7:2], b[7:3]};
            end
            r = curve_at({p[11:8], 4'h0});
            g = curve_at({p[7:4], 4'h0});
            b = curve_at({p[3:0], 4'h0});
            return {p[15:12], r[7:4], g[7:4], b[7:4]};
        endfunction

        function void note_item(logic cmd, logic [7:0] idx, logic [7:0] val,
                                logic [15:0] pix);
            mapped_pixel_t want;
            logic [15:0]   key;
            logic [15:0]   p;
            if (cmd == CMD_LOAD) begin
                load_entry(idx, val);
            end else begin
                want = '0;
                p    = pix;
                key  = key_val;
                if (fmt == FMT_RAW) begin
                    want.pixel = p;
                end else begin
                    if (fmt == FMT_INDEX8) begin
                        p   = {8'h00, pix[7:0]};
                        key = {8'h00, key_val[7:0]};
                    end
                    if (key_en && p == key) begin
                        want.pixel  = p;
                        want.passed = 1'b1;
                    end else begin
                        want.pixel = remap(p);
                        if (key_en && want.pixel == key) begin
                            want.pixel[0] = ~want.pixel[0];
                            want.dodged   = 1'b1;
                        end
                    end
                end
                expected_pixels.push_back(want);
            end
        endfunction

        task report(input string what);
            mismatches++;
            if (mismatches <= MAX_PRINTS) begin
                $display("[%0t] mismatch: %s", $time, what);
            end
        endtask

        task check_result(input logic [15:0] pix, input logic passed, input logic dodged);
            mapped_pixel_t want;
            if (expected_pixels.size() == 0) begin
                report($sformatf("unexpected pixel %h passed %b dodged %b",
                                 pix, passed, dodged));
            end else begin
                want = expected_pixels.pop_front();
                if (pix !== want.pixel || passed !== want.passed || dodged !== want.dodged) begin
                    report($sformatf("pixel %h passed %b dodged %b, want %h %b %b",
                                     pix, passed, dodged,
                                     want.pixel, want.passed, want.dodged));
                end
            end
        endtask
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_idx     = 2'd0;
    logic [15:0] i_cfg_data    = 16'd0;
    logic        i_valid       = 1'b0;
    logic        i_cmd         = 1'b0;
    logic [7:0]  i_entry_index = 8'd0;
    logic [7:0]  i_entry_value = 8'd0;
    logic [15:0] i_pixel_in    = 16'd0;
    logic        i_stall       = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_pixel_out;
    logic        o_key_passed;
    logic        o_key_dodged;

    gamma_scoreboard curve_sb;
    int unsigned     items_accepted = 0;
    int unsigned     cycles         = 0;
    int unsigned     stall_seg      = 0;
    bit              stall_en       = 1'b1;
    bit              gap_en         = 1'b1;
    logic [15:0]     key_seed_pix   = 16'd0;

    gamma_lut_pixel_mapper DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_pixel_in    (i_pixel_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_out   (o_pixel_out),
        .o_key_passed  (o_key_passed),
        .o_key_dodged  (o_key_dodged)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_seg != 0) begin
            stall_seg <= stall_seg - 1;
        end else begin
            stall_seg <= pick_gap();
            i_stall   <= stall_en ? !i_stall : 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            curve_sb.check_result(o_pixel_out, o_key_passed, o_key_dodged);
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] idx, input logic [7:0] val,
                             input logic [15:0] pix);
        int unsigned gap;
        gap = gap_en ? pick_gap() : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_entry_index <= idx;
        i_entry_value <= val;
        i_pixel_in    <= pix;
        do @(posedge i_clk); while (o_stall);
        curve_sb.note_item(cmd, idx, val, pix);
        items_accepted++;
    endtask

    task automatic send_load(input logic [7:0] idx, input logic [7:0] val);
        send_item(CMD_LOAD, idx, val, 16'($urandom));
    endtask

    task automatic send_pixel(input logic [15:0] pix);
        send_item(CMD_PIXEL, 8'($urandom), 8'($urandom), pix);
    endtask

    // drop valid, drain every pending pixel, then let any curve fill finish
    task automatic settle();
        i_valid <= 1'b0;
        while (curve_sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        curve_sb.note_config(idx, data);
    endtask

    task automatic set_mode(input logic [1:0] fmt, input logic inv, input logic ken,
                            input logic [15:0] key, input bit key_from_seed);
        logic [15:0] seeded;
        write_reg(CFG_PIXEL_FORMAT, {14'($urandom), fmt});
        write_reg(CFG_USE_INVERSE, {15'($urandom), inv});
        write_reg(CFG_KEY_ENABLE, {15'($urandom), ken});
        if (key_from_seed) begin
            seeded = curve_sb.remap(key_seed_pix);
            key    = (fmt == FMT_INDEX8) ? {8'($urandom), seeded[7:0]} : seeded;
        end
        write_reg(CFG_KEY_VALUE, key);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] curve_level(curve_style_e style, int i, int prev);
        int nxt;
        case (style)
            CURVE_IDENTITY:  return 8'(i);
            CURVE_SQUARE:    return 8'((i * i) / 255);
            CURVE_WALK: begin
                nxt = prev + $urandom_range(0, 2);
                return (nxt > 255) ? LEVEL_MAX : 8'(nxt);
            end
            CURVE_FLAT_LOW:  return 8'd0;
            CURVE_FLAT_HIGH: return LEVEL_MAX;
            default:         return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic load_curve(input curve_style_e style, input int first);
        int         i;
        logic [7:0] lvl;
        lvl = 8'($urandom_range(0, 16));
        for (i = first; i < 256; i++) begin
            lvl = curve_level(style, i, lvl);
            send_load(8'(i), lvl);
        end
    endtask

    function automatic logic [15:0] key_pixel();
        if (curve_sb.fmt == FMT_INDEX8) begin
            return {8'($urandom), curve_sb.key_val[7:0]};
        end
        return curve_sb.key_val;
    endfunction

    initial begin
        int unsigned  random_end;
        int unsigned  n;
        int unsigned  r;
        logic [1:0]   fmt;
        logic [15:0]  key;
        curve_style_e style;

        curve_sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset mode: RGB565, forward curve, key off
        load_curve(CURVE_SQUARE, 0);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'hF800);
        send_pixel(16'h07E0);
        send_pixel(16'h001F);

        settle();
        set_mode(FMT_INDEX8, 1'b1, 1'b0, 16'h0000, 1'b0);
        send_pixel(16'hFF00);
        send_pixel(16'h00FF);
        send_pixel(16'h5A3C);

        settle();
        set_mode(FMT_ARGB4444, 1'b0, 1'b1, 16'hFFFF, 1'b0);
        send_pixel(16'hF000);
        send_pixel(16'h0FFF);
        send_pixel(16'hFFFF);

        settle();
        set_mode(FMT_RAW, 1'b1, 1'b1, 16'hBEEF, 1'b0);
        send_pixel(16'hBEEF);
        send_pixel(16'h1234);

        settle();
        key_seed_pix = 16'hA5A5;
        set_mode(FMT_RGB565, 1'b1, 1'b1, 16'h0000, 1'b1);
        send_pixel(key_seed_pix);
        send_pixel(key_pixel());
        send_load(8'd0, 8'd40);
        send_load(8'd1, 8'd10);
        send_load(8'd255, 8'd128);
        send_pixel(16'hFFFF);

        settle();
        key_seed_pix = 16'h3380;
        set_mode(FMT_INDEX8, 1'b0, 1'b1, 16'h0000, 1'b1);
        send_pixel(16'h0080);
        send_pixel(16'hFF80);
        send_pixel(key_pixel());

        random_end = items_accepted + RANDOM_ITEMS;
        while (items_accepted < random_end) begin
            settle();
            gap_en   = $urandom_range(0, 3) != 0;
            stall_en <= $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 7))
                0, 1:    fmt = FMT_INDEX8;
                2, 3, 4: fmt = FMT_RGB565;
                5, 6:    fmt = FMT_ARGB4444;
                default: fmt = FMT_RAW;
            endcase
            case ($urandom_range(0, 5))
                0:       key = 16'h0000;
                1:       key = 16'hFFFF;
                default: key = 16'($urandom);
            endcase
            key_seed_pix = 16'($urandom);
            set_mode(fmt, 1'($urandom), $urandom_range(0, 2) != 0, key,
                     $urandom_range(0, 5) > 2);

            n = $urandom_range(40, 120);
            repeat (n) begin
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    send_load(8'($urandom), 8'($urandom));
                end else if (r < 3) begin
                    send_pixel(key_pixel());
                end else if (r < 5) begin
                    send_pixel(key_seed_pix);
                end else begin
                    send_pixel(16'($urandom));
                end
            end

            // sometimes reload the curve for the next mode, in full or from the middle
            style = curve_style_e'($urandom_range(0, 5));
            r     = $urandom_range(0, 9);
            if (r < 2) begin
                load_curve(style, 0);
            end else if (r < 3) begin
                load_curve($urandom_range(0, 1) ? CURVE_WALK : CURVE_NOISE,
                           $urandom_range(1, 254));
            end
        end

        settle();
        if (curve_sb.mismatches == 0 && curve_sb.expected_pixels.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
